FILE: hw/rtl/overspeed_alarm_qualifier_defines.svh
// Assertion macros shared by the overspeed alarm qualifier RTL.
`ifndef OVERSPEED_ALARM_QUALIFIER_DEFINES_SVH
`define OVERSPEED_ALARM_QUALIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OAQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("overspeed alarm qualifier check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("overspeed alarm qualifier check failed");

`endif

FILE: hw/rtl/oaq_pkg.sv
// Package with the types and constants of the overspeed alarm qualifier.
`timescale 1ns / 1ps
`default_nettype none
package oaq_pkg;

  localparam int SPEED_W      = 8;
  localparam int HOLD_W       = 16;
  localparam int VCOUNT_W     = 8;
  localparam int SPACING_W    = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int SECONDS_PER_MINUTE = 60;

  localparam logic [CFG_IDX_W-1:0] REG_ALARM_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_VCOUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_SPACING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY_SPEED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY_HOLD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY_VCOUNT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY_SPACING = 3'd7;

  localparam logic [SPEED_W-1:0]   RST_ALARM_SPEED   = 8'd100;
  localparam logic [HOLD_W-1:0]    RST_ALARM_HOLD    = 16'd10;
  localparam logic [VCOUNT_W-1:0]  RST_ALARM_VCOUNT  = 8'd3;
  localparam logic [SPACING_W-1:0] RST_ALARM_SPACING = 16'd10;
  localparam logic [SPEED_W-1:0]   RST_EARLY_SPEED   = 8'd95;
  localparam logic [HOLD_W-1:0]    RST_EARLY_HOLD    = 16'd3;
  localparam logic [VCOUNT_W-1:0]  RST_EARLY_VCOUNT  = 8'd3;
  localparam logic [SPACING_W-1:0] RST_EARLY_SPACING = 16'd10;

  typedef struct packed {
    logic adv;
    logic clear;
  } persist_ctl_t;

  typedef struct packed {
    logic adv;
    logic active;
  } voice_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/oaq_persist.sv
// Saturating persistence counter that qualifies a speed excess over a hold time.
`timescale 1ns / 1ps
`default_nettype none
module oaq_persist (
  input  wire                         clk,
  input  wire                         rst_n,
  input  oaq_pkg::persist_ctl_t       ctl,
  input  wire                         above,
  input  wire  [oaq_pkg::HOLD_W-1:0]  hold,
  output logic                        hit
);
  import oaq_pkg::*;

  logic [HOLD_W-1:0] cnt_r;
  logic [HOLD_W-1:0] cnt_nxt;
  logic [HOLD_W-1:0] cnt_inc;

  always_comb begin
    cnt_inc = (cnt_r == {HOLD_W{1'b1}}) ? cnt_r : cnt_r + HOLD_W'(1);
    hit     = !ctl.clear && above && (cnt_inc >= hold);
    cnt_nxt = (ctl.clear || !above) ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.adv) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/oaq_voice.sv
// Announcement pacing for one warning level: group timer, count and spacing phase.
`timescale 1ns / 1ps
`default_nettype none
module oaq_voice #(
  parameter int GROUP_MINUTES = 5
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  oaq_pkg::voice_ctl_t            ctl,
  input  wire  [oaq_pkg::VCOUNT_W-1:0]   voice_count,
  input  wire  [oaq_pkg::SPACING_W-1:0]  voice_spacing,
  output logic                           pulse
);
  import oaq_pkg::*;

  localparam int GROUP_TICKS = GROUP_MINUTES * SECONDS_PER_MINUTE;
  localparam int TIMER_W     = $clog2(GROUP_TICKS + 1);

  logic [TIMER_W-1:0]   timer_r;
  logic [TIMER_W-1:0]   timer_nxt;
  logic [TIMER_W-1:0]   timer_inc;
  logic [VCOUNT_W-1:0]  ann_r;
  logic [VCOUNT_W-1:0]  ann_nxt;
  logic [SPACING_W-1:0] phase_r;
  logic [SPACING_W-1:0] phase_nxt;
  logic [SPACING_W:0]   phase_inc;

  always_comb begin
    timer_inc = timer_r + TIMER_W'(1);
    phase_inc = '0;
    pulse     = 1'b0;
    timer_nxt = '0;
    ann_nxt   = '0;
    phase_nxt = '0;
    if (ctl.active) begin
      if (timer_inc < TIMER_W'(GROUP_TICKS)) begin
        timer_nxt = timer_inc;
        ann_nxt   = ann_r;
        phase_nxt = phase_r;
      end
      if (ann_nxt < voice_count) begin
        if (phase_nxt == '0) begin
          ann_nxt = ann_nxt + VCOUNT_W'(1);
          pulse   = 1'b1;
        end
        phase_inc = {1'b0, phase_nxt} + (SPACING_W + 1)'(1);
        phase_nxt = (phase_inc >= {1'b0, voice_spacing}) ? '0 : phase_inc[SPACING_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      ann_r   <= '0;
      phase_r <= '0;
    end else if (ctl.adv) begin
      timer_r <= timer_nxt;
      ann_r   <= ann_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/overspeed_alarm_qualifier.sv
// Top level of the overspeed alarm qualifier: registers, handshakes and level logic.
//
//   Channel  Direction  Handshake            Payload
//   in_      sink       in_valid / in_stall  in_speed, in_speed_ready
//   out_     source     out_valid/out_stall  out_alarm_active, out_early_active,
//                                            out_announce_alarm, out_announce_early
//   cfg_     sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A beat is held in the input register and then moves to the result register, where its
// result is offered; a beat can be taken every cycle while the result side does not stall.
// Each beat after the start advances the persistence and announcement state once.
// Reset is synchronous, clears the valid and start flags and the counters, and loads the register defaults.
// A stalled result holds the result register, which in turn stalls the input side.
`timescale 1ns / 1ps
`default_nettype none
`include "overspeed_alarm_qualifier_defines.svh"
module overspeed_alarm_qualifier #(
  parameter int ALARM_GROUP_MINUTES = 5,
  parameter int EARLY_GROUP_MINUTES = 5
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [oaq_pkg::SPEED_W-1:0]     in_speed,
  input  wire                             in_speed_ready,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_alarm_active,
  output logic                            out_early_active,
  output logic                            out_announce_alarm,
  output logic                            out_announce_early,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [oaq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [oaq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import oaq_pkg::*;

  logic [SPEED_W-1:0]   alarm_speed_r;
  logic [HOLD_W-1:0]    alarm_hold_r;
  logic [VCOUNT_W-1:0]  alarm_vcount_r;
  logic [SPACING_W-1:0] alarm_spacing_r;
  logic [SPEED_W-1:0]   early_speed_r;
  logic [HOLD_W-1:0]    early_hold_r;
  logic [VCOUNT_W-1:0]  early_vcount_r;
  logic [SPACING_W-1:0] early_spacing_r;

  logic                 s1_valid_r;
  logic [SPEED_W-1:0]   s1_speed_r;
  logic                 s1_ready_r;
  logic                 started_r;
  logic                 started_nxt;
  logic                 out_valid_r;
  logic                 out_alarm_r;
  logic                 out_early_r;
  logic                 out_ann_alarm_r;
  logic                 out_ann_early_r;

  logic                 out_free;
  logic                 s1_adv;
  logic                 in_take;
  logic                 tick;
  logic                 alarm_hit;
  logic                 early_hit;
  logic                 alarm_pulse;
  logic                 early_pulse;
  persist_ctl_t         alarm_pctl;
  persist_ctl_t         early_pctl;
  voice_ctl_t           alarm_vctl;
  voice_ctl_t           early_vctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_speed_r   <= RST_ALARM_SPEED;
      alarm_hold_r    <= RST_ALARM_HOLD;
      alarm_vcount_r  <= RST_ALARM_VCOUNT;
      alarm_spacing_r <= RST_ALARM_SPACING;
      early_speed_r   <= RST_EARLY_SPEED;
      early_hold_r    <= RST_EARLY_HOLD;
      early_vcount_r  <= RST_EARLY_VCOUNT;
      early_spacing_r <= RST_EARLY_SPACING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALARM_SPEED:   alarm_speed_r   <= cfg_data[SPEED_W-1:0];
        REG_ALARM_HOLD:    alarm_hold_r    <= cfg_data[HOLD_W-1:0];
        REG_ALARM_VCOUNT:  alarm_vcount_r  <= cfg_data[VCOUNT_W-1:0];
        REG_ALARM_SPACING: alarm_spacing_r <= cfg_data[SPACING_W-1:0];
        REG_EARLY_SPEED:   early_speed_r   <= cfg_data[SPEED_W-1:0];
        REG_EARLY_HOLD:    early_hold_r    <= cfg_data[HOLD_W-1:0];
        REG_EARLY_VCOUNT:  early_vcount_r  <= cfg_data[VCOUNT_W-1:0];
        REG_EARLY_SPACING: early_spacing_r <= cfg_data[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free    = !out_valid_r || !out_stall;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_stall    = s1_valid_r && !out_free;
  assign in_take     = in_valid && !in_stall;
  assign tick        = s1_adv && started_r;
  assign started_nxt = started_r || (s1_adv && s1_ready_r);

  assign alarm_pctl = '{adv: tick, clear: 1'b0};
  assign early_pctl = '{adv: tick, clear: alarm_hit};
  assign alarm_vctl = '{adv: tick, active: alarm_hit};
  assign early_vctl = '{adv: tick, active: early_hit};

  oaq_persist u_alarm_persist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alarm_pctl),
    .above (s1_speed_r > alarm_speed_r),
    .hold  (alarm_hold_r),
    .hit   (alarm_hit)
  );

  oaq_persist u_early_persist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (early_pctl),
    .above (s1_speed_r > early_speed_r),
    .hold  (early_hold_r),
    .hit   (early_hit)
  );

  oaq_voice #(
    .GROUP_MINUTES (ALARM_GROUP_MINUTES)
  ) u_alarm_voice (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (alarm_vctl),
    .voice_count   (alarm_vcount_r),
    .voice_spacing (alarm_spacing_r),
    .pulse         (alarm_pulse)
  );

  oaq_voice #(
    .GROUP_MINUTES (EARLY_GROUP_MINUTES)
  ) u_early_voice (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (early_vctl),
    .voice_count   (early_vcount_r),
    .voice_spacing (early_spacing_r),
    .pulse         (early_pulse)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      started_r <= started_nxt;
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_speed_r <= in_speed;
      s1_ready_r <= in_speed_ready;
    end
    if (s1_adv) begin
      out_alarm_r     <= started_r && alarm_hit;
      out_early_r     <= started_r && early_hit;
      out_ann_alarm_r <= started_r && alarm_pulse;
      out_ann_early_r <= started_r && early_pulse;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_alarm_active   = out_alarm_r;
  assign out_early_active   = out_early_r;
  assign out_announce_alarm = out_ann_alarm_r;
  assign out_announce_early = out_ann_early_r;

  `OAQ_ASSERT_NOW(a_levels_exclusive, clk, rst_n, out_valid_r, !(out_alarm_r && out_early_r))
  `OAQ_ASSERT_NOW(a_alarm_pulse_level, clk, rst_n, out_valid_r && out_ann_alarm_r, out_alarm_r)
  `OAQ_ASSERT_NOW(a_early_pulse_level, clk, rst_n, out_valid_r && out_ann_early_r, out_early_r)
  `OAQ_ASSERT_NEXT(a_idle_quiet, clk, rst_n, s1_adv && !started_r,
                   !out_alarm_r && !out_early_r && !out_ann_alarm_r && !out_ann_early_r)

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the overspeed alarm qualifier with a predictor.
`timescale 1ns / 1ps
module testbench;
  import oaq_pkg::*;

  localparam int ALARM_GROUP_MINUTES = 5;
  localparam int EARLY_GROUP_MINUTES = 5;
  localparam int ALARM_GROUP_TICKS = ALARM_GROUP_MINUTES * SECONDS_PER_MINUTE;
  localparam int EARLY_GROUP_TICKS = EARLY_GROUP_MINUTES * SECONDS_PER_MINUTE;
  localparam int PIPE_LATENCY = 2;
  localparam int QUIET_LIMIT = 1000;

  typedef enum int {LVL_ALARM, LVL_EARLY} level_e;
  typedef enum int {BAND_OVER_ALARM, BAND_OVER_EARLY, BAND_BELOW, BAND_ANY} band_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  typedef struct packed {
    logic alarm_active;
    logic early_active;
    logic announce_alarm;
    logic announce_early;
  } tick_result_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic ready;
    logic typed;
    tick_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SPEED_W-1:0] in_speed = '0;
  logic in_speed_ready = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_alarm_active;
  logic out_early_active;
  logic out_announce_alarm;
  logic out_announce_early;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  overspeed_alarm_qualifier #(
    .ALARM_GROUP_MINUTES(ALARM_GROUP_MINUTES),
    .EARLY_GROUP_MINUTES(EARLY_GROUP_MINUTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_speed(in_speed),
    .in_speed_ready(in_speed_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_alarm_active(out_alarm_active),
    .out_early_active(out_early_active),
    .out_announce_alarm(out_announce_alarm),
    .out_announce_early(out_announce_early),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Qualifier model state and its copy of the registers.
  logic [SPEED_W-1:0] alarm_thr = RST_ALARM_SPEED;
  logic [HOLD_W-1:0] alarm_hold = RST_ALARM_HOLD;
  logic [VCOUNT_W-1:0] alarm_quota = RST_ALARM_VCOUNT;
  logic [SPACING_W-1:0] alarm_gap = RST_ALARM_SPACING;
  logic [SPEED_W-1:0] early_thr = RST_EARLY_SPEED;
  logic [HOLD_W-1:0] early_hold = RST_EARLY_HOLD;
  logic [VCOUNT_W-1:0] early_quota = RST_EARLY_VCOUNT;
  logic [SPACING_W-1:0] early_gap = RST_EARLY_SPACING;

  logic running = 1'b0;
  logic [15:0] alarm_persist = '0;
  logic [15:0] early_persist = '0;
  logic alarm_on = 1'b0;
  logic early_on = 1'b0;
  logic [13:0] grp_timer [2] = '{14'd0, 14'd0};
  logic [7:0] announced [2] = '{8'd0, 8'd0};
  logic [15:0] phase [2] = '{16'd0, 16'd0};

  tick_result_t results_due [$];
  int fail_count = 0;
  int sender_pct = 0;
  int recv_pct = 0;
  int quiet_cycles = 0;

  stim_row_t script [20] = '{
    {8'd255, 1'b0, 1'b1, 4'b0000},
    {8'd0,   1'b0, 1'b1, 4'b0000},
    {8'd200, 1'b1, 1'b1, 4'b0000},
    {8'd255, 1'b0, 1'b1, 4'b0000},
    {8'd255, 1'b1, 1'b1, 4'b0000},
    {8'd255, 1'b0, 1'b1, 4'b0101},
    {8'd255, 1'b1, 1'b0, 4'b0000},
    {8'd255, 1'b0, 1'b0, 4'b0000},
    {8'd255, 1'b1, 1'b0, 4'b0000},
    {8'd255, 1'b0, 1'b0, 4'b0000},
    {8'd255, 1'b0, 1'b0, 4'b0000},
    {8'd255, 1'b1, 1'b0, 4'b0000},
    {8'd255, 1'b0, 1'b1, 4'b1010},
    {8'd101, 1'b0, 1'b0, 4'b0000},
    {8'd100, 1'b1, 1'b0, 4'b0000},
    {8'd96,  1'b0, 1'b0, 4'b0000},
    {8'd96,  1'b1, 1'b0, 4'b0000},
    {8'd95,  1'b0, 1'b0, 4'b0000},
    {8'd0,   1'b1, 1'b0, 4'b0000},
    {8'd255, 1'b0, 1'b0, 4'b0000}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_voice(level_e lv);
    grp_timer[lv] = '0;
    announced[lv] = '0;
    phase[lv] = '0;
  endfunction

  function automatic logic voice_step(level_e lv, logic [7:0] quota, logic [15:0] gap,
                                      int group_ticks);
    logic due;
    int nxt;
    due = 1'b0;
    grp_timer[lv] = grp_timer[lv] + 1'b1;
    if (grp_timer[lv] >= group_ticks) begin
      clear_voice(lv);
    end
    if (announced[lv] < quota) begin
      if (phase[lv] == 0) begin
        announced[lv] = announced[lv] + 1'b1;
        due = 1'b1;
      end
      nxt = phase[lv] + 1;
      phase[lv] = (nxt >= gap) ? 16'd0 : nxt[15:0];
    end
    return due;
  endfunction

  function automatic tick_result_t predict_tick(logic [SPEED_W-1:0] spd, logic rdy);
    tick_result_t r;
    logic alarm_now;
    logic early_now;
    r = '0;
    if (!running) begin
      if (rdy) begin
        running = 1'b1;
      end
    end else begin
      alarm_now = 1'b0;
      if (spd > alarm_thr) begin
        alarm_persist = (alarm_persist == 16'hFFFF) ? alarm_persist : alarm_persist + 1'b1;
        alarm_now = (alarm_persist >= alarm_hold);
      end else begin
        alarm_persist = '0;
      end
      if (alarm_now) begin
        early_persist = '0;
        early_on = 1'b0;
        alarm_on = 1'b1;
        clear_voice(LVL_EARLY);
        r.announce_alarm = voice_step(LVL_ALARM, alarm_quota, alarm_gap, ALARM_GROUP_TICKS);
      end else begin
        alarm_on = 1'b0;
        clear_voice(LVL_ALARM);
        early_now = 1'b0;
        if (spd > early_thr) begin
          early_persist = (early_persist == 16'hFFFF) ? early_persist : early_persist + 1'b1;
          early_now = (early_persist >= early_hold);
        end else begin
          early_persist = '0;
        end
        if (early_now) begin
          early_on = 1'b1;
          r.announce_early = voice_step(LVL_EARLY, early_quota, early_gap, EARLY_GROUP_TICKS);
        end else begin
          early_on = 1'b0;
          clear_voice(LVL_EARLY);
        end
      end
    end
    r.alarm_active = alarm_on;
    r.early_active = early_on;
    return r;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ALARM_SPEED: alarm_thr = data[SPEED_W-1:0];
      REG_ALARM_HOLD: alarm_hold = data[HOLD_W-1:0];
      REG_ALARM_VCOUNT: alarm_quota = data[VCOUNT_W-1:0];
      REG_ALARM_SPACING: alarm_gap = data[SPACING_W-1:0];
      REG_EARLY_SPEED: early_thr = data[SPEED_W-1:0];
      REG_EARLY_HOLD: early_hold = data[HOLD_W-1:0];
      REG_EARLY_VCOUNT: early_quota = data[VCOUNT_W-1:0];
      REG_EARLY_SPACING: early_gap = data[SPACING_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] pick_speed(band_e band);
    case (band)
      BAND_OVER_ALARM: begin
        if (alarm_thr == 8'hFF) begin
          return SPEED_W'($urandom_range(255, 0));
        end
        return SPEED_W'($urandom_range(255, alarm_thr + 1));
      end
      BAND_OVER_EARLY: begin
        if (early_thr >= alarm_thr) begin
          return SPEED_W'($urandom_range(255, 0));
        end
        return SPEED_W'($urandom_range(alarm_thr, early_thr + 1));
      end
      BAND_BELOW: return SPEED_W'($urandom_range(early_thr, 0));
      default: return SPEED_W'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic check_field(string name, logic want, logic got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
    end
  endtask

  task automatic set_idle(idle_e mode);
    sender_pct = (mode == IDLE_SENDER) ? 48 : (mode == IDLE_BOTH) ? 32 : 0;
    recv_pct = (mode == IDLE_RECEIVER) ? 48 : (mode == IDLE_BOTH) ? 32 : 0;
  endtask

  task automatic send_tick(input logic [SPEED_W-1:0] spd, input logic rdy,
                           output tick_result_t predicted);
    while (sender_pct != 0 && $urandom_range(99) < sender_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_speed <= spd;
    in_speed_ready <= rdy;
    do @(posedge clk); while (in_stall);
    predicted = predict_tick(spd, rdy);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, data);
  endtask

  task automatic run_phase(input logic [7:0] a_spd, input logic [15:0] a_hold,
                           input logic [7:0] a_cnt, input logic [15:0] a_gap,
                           input logic [7:0] e_spd, input logic [15:0] e_hold,
                           input logic [7:0] e_cnt, input logic [15:0] e_gap,
                           input int beats, input idle_e mode, input bit sustain,
                           input int soak);
    tick_result_t p;
    band_e band;
    int sent;
    int len;
    int w;
    drain_results();
    // The upper byte of the narrow registers carries random junk.
    write_reg(REG_ALARM_SPEED, {8'($urandom_range(255, 0)), a_spd});
    write_reg(REG_ALARM_HOLD, a_hold);
    write_reg(REG_ALARM_VCOUNT, {8'($urandom_range(255, 0)), a_cnt});
    write_reg(REG_ALARM_SPACING, a_gap);
    write_reg(REG_EARLY_SPEED, {8'($urandom_range(255, 0)), e_spd});
    write_reg(REG_EARLY_HOLD, e_hold);
    write_reg(REG_EARLY_VCOUNT, {8'($urandom_range(255, 0)), e_cnt});
    write_reg(REG_EARLY_SPACING, e_gap);
    cfg_valid <= 1'b0;
    set_idle(mode);
    for (int k = 0; k < soak; k++) begin
      send_tick(8'd255, 1'($urandom_range(1, 0)), p);
      results_due.push_back(p);
    end
    if (sustain) begin
      for (int k = 0; k < 25; k++) begin
        send_tick(pick_speed(BAND_OVER_ALARM), 1'($urandom_range(1, 0)), p);
        results_due.push_back(p);
      end
    end
    sent = 0;
    while (sent < beats) begin
      w = $urandom_range(99);
      band = (w < 40) ? BAND_OVER_ALARM : (w < 65) ? BAND_OVER_EARLY :
             (w < 85) ? BAND_BELOW : BAND_ANY;
      len = $urandom_range(25, 1);
      for (int k = 0; k < len && sent < beats; k++) begin
        send_tick(pick_speed(band), 1'($urandom_range(1, 0)), p);
        results_due.push_back(p);
        sent++;
      end
    end
    if (sustain) begin
      for (int k = 0; k < 25; k++) begin
        send_tick(pick_speed(BAND_OVER_ALARM), 1'($urandom_range(1, 0)), p);
        results_due.push_back(p);
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat, expected none, actual %b%b%b%b", $time,
                 out_alarm_active, out_early_active, out_announce_alarm,
                 out_announce_early);
      end else begin
        want = results_due.pop_front();
        check_field("alarm_active", want.alarm_active, out_alarm_active);
        check_field("early_active", want.early_active, out_early_active);
        check_field("announce_alarm", want.announce_alarm, out_announce_alarm);
        check_field("announce_early", want.announce_early, out_announce_early);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    tick_result_t p;
    set_idle(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_tick(script[i].speed, script[i].ready, p);
      results_due.push_back(script[i].typed ? script[i].want : p);
    end

    run_phase(8'd120, 16'd5, 8'd4, 16'd3, 8'd80, 16'd2, 8'd2, 16'd4,
              45, IDLE_NONE, 1'b0, 0);
    run_phase(8'd255, 16'd0, 8'd255, 16'd1, 8'd0, 16'd0, 8'd255, 16'd1,
              45, IDLE_SENDER, 1'b0, 0);
    run_phase(8'd0, 16'd1, 8'd0, 16'd65535, 8'd255, 16'd65535, 8'd0, 16'd0,
              40, IDLE_RECEIVER, 1'b0, 0);
    run_phase(8'd50, 16'd2, 8'd5, 16'd0, 8'd30, 16'd1, 8'd3, 16'd2,
              45, IDLE_BOTH, 1'b0, 0);
    run_phase(8'd10, 16'd0, 8'd255, 16'd20, 8'd5, 16'd1, 8'd2, 16'd3,
              30, IDLE_SENDER, 1'b1, 0);
    // Spacing drops while an alarm group is in progress.
    run_phase(8'd10, 16'd0, 8'd255, 16'd3, 8'd5, 16'd1, 8'd2, 16'd0,
              35, IDLE_RECEIVER, 1'b1, 0);
    // Alarm hold far beyond the run, so only the early warning qualifies.
    run_phase(8'd0, 16'd65535, 8'd2, 16'd100, 8'd0, 16'd3, 8'd1, 16'd5,
              40, IDLE_NONE, 1'b0, 0);
    run_phase(RST_ALARM_SPEED, RST_ALARM_HOLD, RST_ALARM_VCOUNT, RST_ALARM_SPACING,
              RST_EARLY_SPEED, RST_EARLY_HOLD, RST_EARLY_VCOUNT, RST_EARLY_SPACING,
              50, IDLE_BOTH, 1'b0, 0);

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
